// File: design/lmfb_pkg.sv
`default_nettype none

package lmfb_pkg;

    // Operation codes of a request.
    localparam logic [2:0] OP_SET_PIXEL = 3'd0;
    localparam logic [2:0] OP_CLR_PIXEL = 3'd1;
    localparam logic [2:0] OP_BLIT_ROW  = 3'd2;
    localparam logic [2:0] OP_CLR_STORE = 3'd3;
    localparam logic [2:0] OP_SHOW      = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [5:0] x;
        logic [3:0] y;
        logic [7:0] row_bits;
        logic [3:0] glyph_width;
    } t_req;

    typedef struct packed {
        logic [3:0] row_register;
        logic [7:0] pixel_byte;
        logic       frame_end;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

// File: design/led_matrix_frame_buffer.sv
// In-range pixel set/clear and a blit without spill keep busy high through ST_MOD after the
// request; a spilling blit keeps it high through ST_MOD and then ST_SPILL, with
// one read-modify-write of the frame memory per touched byte.
// Show: results start the cycle after the request, one word per cycle for 8*CHAINED_DISPLAYS
// words, never stalled by the receiver; busy stays high for the run. Clear store, dropped
// writes and unused opcodes never raise busy. Synchronous active-low reset clears the store.
`default_nettype none

module led_matrix_frame_buffer #(
    parameter int CHAINED_DISPLAYS = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    input  wire lmfb_pkg::t_req i_req,
    output logic              busy,
    output logic              o_strobe,
    output lmfb_pkg::t_result o_result
);
    import lmfb_pkg::*;

    localparam int DEPTH = 8 * CHAINED_DISPLAYS;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = (CHAINED_DISPLAYS > 1) ? $clog2(CHAINED_DISPLAYS) : 1;
    localparam logic [BW-1:0] LAST_BLK = BW'(CHAINED_DISPLAYS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MOD   = 2'd1;
    localparam logic [1:0] ST_SPILL = 2'd2;
    localparam logic [1:0] ST_SHOW  = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;
    logic          r_rd_vld;
    logic [DEPTH-1:0] r_valid;

    logic [2:0]    r_op;
    logic [2:0]    r_pos;
    logic [7:0]    r_bits;
    logic          r_spill;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_spill_addr;
    logic [2:0]    r_row, n_row;
    logic [BW-1:0] r_blk, n_blk;

    logic          accept;
    logic          blk_ok;
    logic          row_ok;
    logic          spill;
    logic [6:0]    addr_full;
    logic [6:0]    spill_full;
    logic [6:0]    show_full;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic [7:0]    rd;
    logic [15:0]   shifted;
    logic [7:0]    bit_mask;
    logic          show_done;

    assign accept = start && !busy;
    assign busy   = (r_state != ST_IDLE);

    assign blk_ok = ({1'b0, i_req.x[5:3]} < 4'(CHAINED_DISPLAYS));
    assign row_ok = !i_req.y[3];
    // Spill only when the glyph crosses the block edge and ends inside the display.
    assign spill  = ((5'({2'b0, i_req.x[2:0]}) + 5'(i_req.glyph_width)) > 5'd8)
                 && ((7'(i_req.x) + 7'(i_req.glyph_width)) < 7'(DEPTH))
                 && ((4'(i_req.x[5:3]) + 4'd1) < 4'(CHAINED_DISPLAYS));

    assign addr_full  = {1'b0, i_req.x[5:3], i_req.y[2:0]};
    assign spill_full = {(4'(i_req.x[5:3]) + 4'd1), i_req.y[2:0]};
    assign show_full  = {4'(n_blk), n_row};

    assign rd       = r_rd_vld ? r_rd_data : 8'h00;
    assign shifted  = {8'h00, r_bits} << r_pos;
    assign bit_mask = 8'h01 << r_pos;
    assign show_done = (r_row == 3'd7) && (r_blk == '0);

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_blk   = r_blk;
        rd_addr = addr_full[AW-1:0];
        we      = 1'b0;
        wr_addr = r_addr;
        wr_data = rd | shifted[7:0];
        case (r_state)
            ST_IDLE: begin
                n_row = 3'd0;
                n_blk = LAST_BLK;
                if (accept && i_req.op == OP_SHOW) begin
                    rd_addr = show_full[AW-1:0];
                    n_state = ST_SHOW;
                end else if (accept && (i_req.op inside {OP_SET_PIXEL, OP_CLR_PIXEL,
                                                         OP_BLIT_ROW})
                             && blk_ok && row_ok) begin
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                we = 1'b1;
                if (r_op == OP_SET_PIXEL) begin
                    wr_data = rd | bit_mask;
                end else if (r_op == OP_CLR_PIXEL) begin
                    wr_data = rd & ~bit_mask;
                end
                rd_addr = r_spill_addr;
                n_state = r_spill ? ST_SPILL : ST_IDLE;
            end
            ST_SPILL: begin
                we      = 1'b1;
                wr_addr = r_spill_addr;
                wr_data = rd | shifted[15:8];
                rd_addr = r_spill_addr;
                n_state = ST_IDLE;
            end
            ST_SHOW: begin
                if (r_blk == '0) begin
                    n_blk = LAST_BLK;
                    n_row = r_row + 3'd1;
                end else begin
                    n_blk = r_blk - BW'(1);
                end
                rd_addr = show_full[AW-1:0];
                if (show_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_valid[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (accept && i_req.op == OP_CLR_STORE) begin
            r_valid <= '0;
        end else if (we) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= 3'd0;
            r_blk   <= LAST_BLK;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_blk   <= n_blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= i_req.op;
            r_pos        <= i_req.x[2:0];
            r_bits       <= i_req.row_bits;
            r_spill      <= spill && (i_req.op == OP_BLIT_ROW);
            r_addr       <= addr_full[AW-1:0];
            r_spill_addr <= spill_full[AW-1:0];
        end
    end

    assign o_strobe              = (r_state == ST_SHOW);
    assign o_result.row_register = 4'd8 - {1'b0, r_row};
    assign o_result.pixel_byte   = rd;
    assign o_result.frame_end    = (r_blk == '0);
    assign o_result.last         = show_done;

endmodule

`default_nettype wire

// File: design/lmfb_checker.sv
`default_nettype none

module lmfb_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               start,
    input wire lmfb_pkg::t_req    i_req,
    input wire               busy,
    input wire               o_strobe,
    input wire lmfb_pkg::t_result o_result
);
    import lmfb_pkg::*;

    // A show request starts its run on the next cycle at the top row.
    a_show_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.op == OP_SHOW) |=> (o_strobe && o_result.row_register == 4'd8))
        else $error("show run did not start at the top row");

    // Results only appear while the block is busy.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe while not busy");

    // Inside a chip-select group the words come back to back.
    a_group_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.frame_end) |=> o_strobe)
        else $error("gap inside a chip-select group");

    // The final word closes its group and ends the run.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.last) |-> o_result.frame_end ##1 (!o_strobe && !busy))
        else $error("show run did not end after the final word");

endmodule

bind led_matrix_frame_buffer lmfb_checker u_lmfb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_req   (i_req),
    .busy    (busy),
    .o_strobe(o_strobe),
    .o_result(o_result)
);

`default_nettype wire
